@@ hw/rtl/prca_pkg.sv @@
// ----------------------------------------------------------------------------
// prca_pkg
// Shared types and constants of the polygon region color average core.
// ----------------------------------------------------------------------------
package prca_pkg;

  localparam int unsigned NumVertsDef  = 6;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FifoDepthDef = 2;

  localparam int unsigned FieldCoordW = 12;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned SumW        = 32;
  localparam int unsigned CountW      = 25;
  localparam int unsigned NumChan     = 3;
  localparam int unsigned DivBits     = 8;

  localparam logic [ChanW-1:0]  MeanMax  = 8'hFF;
  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_VERT = 2'd1,
    OP_PIX  = 2'd2
  } op_e;

  typedef struct packed {
    logic                   req_type;
    logic [2:0]             vert_index;
    logic [FieldCoordW-1:0] px_x;
    logic [FieldCoordW-1:0] px_y;
    logic [ChanW-1:0]       red;
    logic [ChanW-1:0]       green;
    logic [ChanW-1:0]       blue;
    logic                   last;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0]  mean_red;
    logic [ChanW-1:0]  mean_green;
    logic [ChanW-1:0]  mean_blue;
    logic [CountW-1:0] pixel_count;
    logic              empty_res;
  } out_t;

  typedef struct packed {
    op_e op;
    in_t data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

@@ hw/rtl/prca_front.sv @@
// ----------------------------------------------------------------------------
// prca_front
// Accepts transactions and classifies them as vertex load, pixel or no-op.
// ----------------------------------------------------------------------------
`default_nettype none

module prca_front #(
  parameter int unsigned NumVerts = prca_pkg::NumVertsDef
) (
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  prca_pkg::in_t    in_data_i,
  input  wire              q_full_i,
  output logic             q_push_o,
  output prca_pkg::item_t  q_item_o
);

  prca_pkg::op_e op;

  always_comb begin
    if (in_data_i.req_type) begin
      op = prca_pkg::OP_PIX;
    end else if (32'(in_data_i.vert_index) < 32'(NumVerts)) begin
      op = prca_pkg::OP_VERT;
    end else begin
      op = prca_pkg::OP_NOP;
    end
  end

  assign in_ready_o    = !q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign q_item_o.op   = op;
  assign q_item_o.data = in_data_i;

endmodule

`default_nettype wire

@@ hw/rtl/prca_fifo.sv @@
// ----------------------------------------------------------------------------
// prca_fifo
// Short queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module prca_fifo #(
  parameter int unsigned Depth = prca_pkg::FifoDepthDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  prca_pkg::item_t  item_i,
  output logic             full_o,
  input  wire              pop_i,
  output prca_pkg::qhead_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  prca_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/prca_back.sv @@
// ----------------------------------------------------------------------------
// prca_back
// Executes queued transactions: vertex store, edge walk, sums, mean divider.
// ----------------------------------------------------------------------------
`default_nettype none

module prca_back #(
  parameter int unsigned NumVerts  = prca_pkg::NumVertsDef,
  parameter int unsigned CoordBits = prca_pkg::CoordBitsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  prca_pkg::qhead_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output prca_pkg::out_t   out_data_o
);

  localparam int unsigned CW   = CoordBits;
  localparam int unsigned PW   = 2 * CW + 3;
  localparam int unsigned EW   = $clog2(NumVerts + 1);
  localparam int unsigned IW   = $clog2(NumVerts);
  localparam int unsigned NC   = prca_pkg::NumChan;
  localparam int unsigned SW   = prca_pkg::SumW;
  localparam int unsigned KW   = prca_pkg::CountW;
  localparam int unsigned QW   = prca_pkg::ChanW;
  localparam int unsigned BW   = $clog2(prca_pkg::DivBits + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EDGE = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] vx_q [NumVerts];
  logic [CW-1:0] vy_q [NumVerts];

  logic [CW-1:0] cx_q, cy_q, xj_q, yj_q;
  logic [CW-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic [QW-1:0] col_q [NC];
  logic          last_q;
  logic [EW-1:0] edge_q;
  logic          parity_q;

  logic signed [PW-1:0] p1_q, p2_q;
  logic                 cond_q, dpos_q, aneg_q, vld_q;

  logic [SW-1:0] sum_q [NC];
  logic [KW-1:0] cnt_q;
  logic [SW-1:0] rem_q [NC];
  logic [QW-1:0] quo_q [NC];
  logic          clamp_q [NC];
  logic [KW-1:0] dcnt_q;
  logic [BW-1:0] bit_q;

  logic           out_valid_q;
  prca_pkg::out_t out_q;

  // edge datapath
  logic [IW-1:0]       vidx;
  logic [CW-1:0]       xi, yi, px, py;
  logic signed [CW:0]  dx, dyp, dd, da;
  logic signed [CW+1:0] kv;
  logic signed [PW-1:0] p1, p2;
  logic                cond, hit;

  assign vidx = (edge_q < EW'(NumVerts)) ? edge_q[IW-1:0] : '0;
  assign xi   = vx_q[vidx];
  assign yi   = vy_q[vidx];
  assign px   = CW'(head_i.item.data.px_x);
  assign py   = CW'(head_i.item.data.px_y);
  assign dx   = $signed({1'b0, xj_q}) - $signed({1'b0, xi});
  assign dyp  = $signed({1'b0, cy_q}) - $signed({1'b0, yi});
  assign dd   = $signed({1'b0, yj_q}) - $signed({1'b0, yi});
  assign da   = $signed({1'b0, cx_q}) - $signed({1'b0, xi});
  assign kv   = $signed({da[CW], da}) + $signed({{(CW + 1){1'b0}}, ~da[CW]});
  assign p1   = dx * dyp;
  assign p2   = kv * dd;
  assign cond = (yi > cy_q) != (yj_q > cy_q);

  always_comb begin
    if (aneg_q) begin
      hit = dpos_q ? (p1_q > p2_q) : (p1_q < p2_q);
    end else begin
      hit = dpos_q ? (p1_q >= p2_q) : (p1_q <= p2_q);
    end
  end

  // accumulate
  logic          in_region;
  logic [SW-1:0] nsum [NC];
  logic [SW:0]   ssum [NC];
  logic [KW-1:0] ncnt;

  assign in_region = parity_q && (cx_q >= minx_q) && (cx_q < maxx_q)
                     && (cy_q >= miny_q) && (cy_q < maxy_q);

  always_comb begin
    for (int l = 0; l < NC; l++) begin
      ssum[l] = {1'b0, sum_q[l]} + (SW + 1)'(col_q[l]);
      if (!in_region) begin
        nsum[l] = sum_q[l];
      end else if (ssum[l][SW]) begin
        nsum[l] = prca_pkg::SumMax;
      end else begin
        nsum[l] = ssum[l][SW-1:0];
      end
    end
    ncnt = (in_region && cnt_q != prca_pkg::CountMax) ? cnt_q + KW'(1) : cnt_q;
  end

  // divider step
  logic [SW:0] sh;
  logic        ge [NC];
  logic        can_load;

  assign sh       = (SW + 1)'(dcnt_q) << bit_q;
  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    for (int l = 0; l < NC; l++) begin
      ge[l] = {1'b0, rem_q[l]} >= sh;
    end
  end

  assign pop_o = (state_q == ST_IDLE) && head_i.valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && head_i.item.op == prca_pkg::OP_PIX) begin
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (edge_q == EW'(NumVerts)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = last_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= 1'b0;
      cnt_q       <= '0;
      for (int v = 0; v < NumVerts; v++) begin
        vx_q[v] <= '0;
        vy_q[v] <= '0;
      end
      for (int l = 0; l < NC; l++) begin
        sum_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      vld_q   <= (state_q == ST_EDGE) && (edge_q != EW'(NumVerts));
      if (state_q == ST_OUT && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && head_i.item.op == prca_pkg::OP_VERT) begin
        for (int v = 0; v < NumVerts; v++) begin
          if (32'(head_i.item.data.vert_index) == 32'(v)) begin
            vx_q[v] <= px;
            vy_q[v] <= py;
          end
        end
      end
      if (state_q == ST_ACC) begin
        for (int l = 0; l < NC; l++) begin
          sum_q[l] <= last_q ? '0 : nsum[l];
        end
        cnt_q <= last_q ? '0 : ncnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.item.op == prca_pkg::OP_PIX) begin
      cx_q     <= px;
      cy_q     <= py;
      col_q[0] <= head_i.item.data.red;
      col_q[1] <= head_i.item.data.green;
      col_q[2] <= head_i.item.data.blue;
      last_q   <= head_i.item.data.last;
      xj_q     <= vx_q[NumVerts-1];
      yj_q     <= vy_q[NumVerts-1];
      minx_q   <= vx_q[0];
      maxx_q   <= vx_q[0];
      miny_q   <= vy_q[0];
      maxy_q   <= vy_q[0];
      edge_q   <= '0;
      parity_q <= 1'b0;
    end
    if (state_q == ST_EDGE) begin
      if (edge_q != EW'(NumVerts)) begin
        p1_q   <= p1;
        p2_q   <= p2;
        cond_q <= cond;
        dpos_q <= !dd[CW] && (dd != '0);
        aneg_q <= da[CW];
        xj_q   <= xi;
        yj_q   <= yi;
        edge_q <= edge_q + EW'(1);
        if (xi < minx_q) minx_q <= xi;
        if (xi > maxx_q) maxx_q <= xi;
        if (yi < miny_q) miny_q <= yi;
        if (yi > maxy_q) maxy_q <= yi;
      end
      if (vld_q && cond_q && hit) begin
        parity_q <= !parity_q;
      end
    end
    if (state_q == ST_ACC) begin
      for (int l = 0; l < NC; l++) begin
        rem_q[l] <= nsum[l];
      end
      dcnt_q <= ncnt;
      bit_q  <= BW'(prca_pkg::DivBits);
    end
    if (state_q == ST_DIV) begin
      for (int l = 0; l < NC; l++) begin
        if (bit_q == BW'(prca_pkg::DivBits)) begin
          clamp_q[l] <= ge[l];
          quo_q[l]   <= '0;
        end else if (ge[l]) begin
          rem_q[l]                 <= rem_q[l] - sh[SW-1:0];
          quo_q[l][bit_q[BW-2:0]] <= 1'b1;
        end
      end
      if (bit_q != '0) begin
        bit_q <= bit_q - BW'(1);
      end
    end
    if (state_q == ST_OUT && can_load) begin
      out_q.pixel_count <= dcnt_q;
      out_q.empty_res   <= (dcnt_q == '0);
      out_q.mean_red    <= (dcnt_q == '0) ? '0 : clamp_q[0] ? prca_pkg::MeanMax : quo_q[0];
      out_q.mean_green  <= (dcnt_q == '0) ? '0 : clamp_q[1] ? prca_pkg::MeanMax : quo_q[1];
      out_q.mean_blue   <= (dcnt_q == '0) ? '0 : clamp_q[2] ? prca_pkg::MeanMax : quo_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/polygon_region_color_average_core.sv @@
// ----------------------------------------------------------------------------
// polygon_region_color_average_core
// Mean RGB color of the pixels inside a polygon, even-odd crossing test.
// ----------------------------------------------------------------------------
// channel  dir  payload            handshake
// in       in   prca_pkg::in_t     in_valid_i / in_ready_o
// out      out  prca_pkg::out_t    out_valid_o / out_ready_i
//
// The back end stores a vertex load as it pops it. A pixel runs the edge walk
// through one shared pair of multipliers, then its sums update; a last pixel
// then runs the bit-serial mean divider and the output load.
// Reset is asynchronous; vertices, sums and count clear at once.
// A 2-entry queue lets input accept while the back end works or the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_region_color_average_core #(
  parameter int unsigned NumVerts  = prca_pkg::NumVertsDef,
  parameter int unsigned CoordBits = prca_pkg::CoordBitsDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  prca_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output prca_pkg::out_t  out_data_o
);

  logic             q_full, q_push, q_pop;
  prca_pkg::item_t  q_item;
  prca_pkg::qhead_t q_head;

  prca_front #(
    .NumVerts (NumVerts)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  prca_fifo #(
    .Depth (prca_pkg::FifoDepthDef)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  prca_back #(
    .NumVerts  (NumVerts),
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/prca_checker.sv @@
// ----------------------------------------------------------------------------
// prca_checker
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prca_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input prca_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.empty_res == (out_data_o.pixel_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_means: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_res |-> out_data_o.mean_red == '0
      && out_data_o.mean_green == '0 && out_data_o.mean_blue == '0)
    else $error("empty region with nonzero mean");

endmodule

bind polygon_region_color_average_core prca_checker u_prca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
